// ----- rtl/core/plid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int TOT_W   = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int CMP_W   = (CNT_W + 1 > POS_W + 1) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic [KIND_W-1:0] {
        K_TRAVERSE  = 3'd0,
        K_INS_FRONT = 3'd1,
        K_INS_BACK  = 3'd2,
        K_INS_POS   = 3'd3,
        K_DEL_FRONT = 3'd4,
        K_DEL_BACK  = 3'd5,
        K_DEL_POS   = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHR,
        S_SHW,
        S_TRD,
        S_TLD,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/plid_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plid_ram (
    input  wire logic                      clk,
    input  wire plid_pkg::ram_req_t        req,
    output logic [plid_pkg::VAL_W-1:0]     rdata
);
    import plid_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/plid_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plid_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [plid_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [plid_pkg::KIND_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [plid_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [plid_pkg::STAT_W-1:0]        m_tuser,
    output logic                               m_tlast,
    output plid_pkg::ram_req_t                 ram_req,
    input  wire logic [plid_pkg::VAL_W-1:0]    ram_rdata
);
    import plid_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    logic             ins_reg, ins_next;
    logic             trav_reg, trav_next;
    logic [VAL_W-1:0] val_reg, val_next;

    status_t          status_reg, status_next;
    logic [VAL_W-1:0] elem_reg, elem_next;
    logic             last_reg, last_next;
    logic [TOT_W-1:0] total_reg, total_next;

    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    kind_t            in_kind;
    logic [CMP_W-1:0] pos_w, cnt_w;
    logic [CNT_W-1:0] step_w;
    logic             full, empty;

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_val  = s_tdata[POS_W+VAL_W-1:POS_W];
    assign in_kind = kind_t'(s_tuser);
    assign pos_w   = CMP_W'(in_pos);
    assign cnt_w   = CMP_W'(cnt_reg);
    assign full    = (cnt_reg >= CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);

    // Shared index unit: walks down for an insert, up for a delete or a traverse.
    assign step_w = ins_reg ? CNT_W'(idx_reg) - CNT_W'(1) : CNT_W'(idx_reg) + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        ins_reg    <= ins_next;
        trav_reg   <= trav_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
        total_reg  <= total_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        tgt_next    = tgt_reg;
        ins_next    = ins_reg;
        trav_next   = trav_reg;
        val_next    = val_reg;
        status_next = status_reg;
        elem_next   = elem_reg;
        last_next   = last_reg;
        total_next  = total_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = step_w[IDX_W-1:0];
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    val_next   = in_val;
                    trav_next  = 1'b0;
                    ins_next   = 1'b0;
                    // Rejected requests produce a single result straight away.
                    elem_next  = '0;
                    last_next  = 1'b1;
                    total_next = TOT_W'(cnt_reg);
                    state_next = S_OUT;
                    case (in_kind)
                        K_TRAVERSE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                trav_next  = 1'b1;
                                idx_next   = '0;
                                state_next = S_TRD;
                            end
                        end
                        K_INS_FRONT, K_INS_BACK, K_INS_POS:
                        begin
                            if (in_kind == K_INS_POS &&
                                (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)))
                            begin
                                status_next = ST_INVALID;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ins_next   = 1'b1;
                                idx_next   = IDX_W'(cnt_reg);
                                state_next = S_SHR;
                                case (in_kind)
                                    K_INS_FRONT: tgt_next = '0;
                                    K_INS_BACK:  tgt_next = IDX_W'(cnt_reg);
                                    default:     tgt_next = IDX_W'(pos_w - CMP_W'(1));
                                endcase
                            end
                        end
                        K_DEL_FRONT, K_DEL_BACK, K_DEL_POS:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (in_kind == K_DEL_POS && (pos_w == '0 || pos_w > cnt_w))
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                state_next = S_SHR;
                                case (in_kind)
                                    K_DEL_FRONT: idx_next = '0;
                                    K_DEL_BACK:  idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                                    default:     idx_next = IDX_W'(pos_w - CMP_W'(1));
                                endcase
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end

            S_SHR:
            begin
                if (ins_reg ? (idx_reg > tgt_reg) : (step_w < cnt_reg))
                begin
                    state_next = S_SHW;
                end
                else
                begin
                    // Shifting is done: place the new value or drop the tail slot.
                    if (ins_reg)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = tgt_reg;
                        ram_req.wdata = val_reg;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    status_next = ST_OK;
                    elem_next   = '0;
                    last_next   = 1'b1;
                    total_next  = TOT_W'(cnt_next);
                    state_next  = S_OUT;
                end
            end

            S_SHW:
            begin
                ram_req.we = 1'b1;
                idx_next   = step_w[IDX_W-1:0];
                state_next = S_SHR;
            end

            S_TRD:
            begin
                ram_req.raddr = idx_reg;
                state_next    = S_TLD;
            end

            S_TLD:
            begin
                status_next = ST_OK;
                elem_next   = ram_rdata;
                last_next   = (step_w == cnt_reg);
                total_next  = TOT_W'(cnt_reg);
                state_next  = S_OUT;
            end

            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (trav_reg && !last_reg)
                    begin
                        idx_next   = step_w[IDX_W-1:0];
                        state_next = S_TRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tdata = {{(M_DATA_W - VAL_W - TOT_W){1'b0}}, total_reg, elem_reg};
    assign m_tuser = status_reg;
    assign m_tlast = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_insert_delete_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: position, value
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: element, entry_total; tlast
//
// One request is handled at a time; s_tready is high only while the sequencer is idle.
// An insert or delete moves each entry with a read and then a write, all through the single
// port pair of the list memory, and then holds its result until it is taken.
// A traverse reads, loads and presents each stored value in turn, stalling on m_tready.
// Reset clears the entry count and the sequencer; the list memory itself is not cleared.

module positional_list_insert_delete_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [plid_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] kind
    input  wire logic [plid_pkg::KIND_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] element, [36:32] entry_total, [39:37] zero
    output logic [plid_pkg::M_DATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [plid_pkg::STAT_W-1:0]        m_tuser,
    output logic                               m_tlast
);
    import plid_pkg::*;

    ram_req_t         ram_req;
    logic [VAL_W-1:0] ram_rdata;

    plid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    plid_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/plid_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plid_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [plid_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic [plid_pkg::STAT_W-1:0]   m_tuser,
    input  wire logic                          m_tlast
);
    import plid_pkg::*;

    // A waiting result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Only one request is in flight, so input and output are never open together.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Once a request is taken, the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepting a request");

    // Any result other than a good one is a lone, final result carrying no element.
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata[VAL_W-1:0] == '0))
        else $error("error result not final or carries an element");

endmodule

bind positional_list_insert_delete_top plid_chk u_plid_chk (.*);

`default_nettype wire
